/* design/mcpwm_pkg.sv */
`timescale 1ns / 1ps

package mcpwm_pkg;

  localparam int PWM_CHANNELS = 4;
  localparam int COUNT_BITS   = 16;
  localparam int CHAN_BITS    = 2;
  localparam int CCOUNT_BITS  = 3;
  localparam int OP_BITS      = 3;

  localparam logic [COUNT_BITS-1:0] RESET_PERIOD = COUNT_BITS'(255);
  localparam logic [CCOUNT_BITS-1:0] RESET_CHANNEL_COUNT = CCOUNT_BITS'(4);

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK    = 3'd0,
    OP_DUTY    = 3'd1,
    OP_PERIOD  = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4
  } op_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  // next view of the shared timebase, handed to the channel bank
  typedef struct packed {
    logic   running;
    logic   wrapped;
    count_t count;
  } tb_view_t;

endpackage

/* design/multi_channel_pwm_generator_core.sv */
`timescale 1ns / 1ps
// a result beat appears in the cycle after its input beat is taken
// throughput: one beat per cycle while results are claimed, counter and shadows update on each taken beat
// the input side stalls only while a result sits unclaimed in the output register
// reset (rst, synchronous, active high): counter 0, period 255, duties 0, running,
// channel count 4, output register empty

module multi_channel_pwm_generator_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: channel count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [4:0]  s_tuser,   // [2:0] op, [4:3] channel
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] pin_levels, [19:4] count_now, [23:20] zero
  output logic [0:0]  m_tuser    // [0] period_wrapped
);
  import mcpwm_pkg::*;

  logic [CCOUNT_BITS-1:0]  channel_count;
  logic                    accept;
  logic [OP_BITS-1:0]      in_op;
  logic [CHAN_BITS-1:0]    in_channel;
  count_t                  in_value;
  tb_view_t                view;
  logic [PWM_CHANNELS-1:0] levels;

  // result register
  logic [PWM_CHANNELS-1:0] pin_levels;
  count_t                  count_now;
  logic                    period_wrapped;
  logic                    out_valid;

  // configuration is taken at any time, the channel count is a plain register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RESET_CHANNEL_COUNT;
    end else if (cfg_valid) begin
      channel_count <= cfg_data;
    end
  end

  // unpack the input beat
  assign in_op      = s_tuser[OP_BITS-1:0];
  assign in_channel = s_tuser[OP_BITS+CHAN_BITS-1:OP_BITS];
  assign in_value   = s_tdata[COUNT_BITS-1:0];

  // a new beat is taken whenever the result register is empty or being drained
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // shared counter with period shadow, run/stop
  mcpwm_timebase u_timebase (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (in_op),
    .value  (in_value),
    .view   (view)
  );

  // duty shadows and per-channel compare against the updated count
  mcpwm_channels u_channels (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .op            (in_op),
    .channel       (in_channel),
    .value         (in_value),
    .channel_count (channel_count),
    .view          (view),
    .levels        (levels)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with the state as it stands after the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      pin_levels     <= levels;
      count_now      <= view.count;
      period_wrapped <= view.wrapped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, count_now, pin_levels};
  assign m_tuser  = period_wrapped;

endmodule

/* design/mcpwm_timebase.sv */
`timescale 1ns / 1ps

module mcpwm_timebase (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [mcpwm_pkg::OP_BITS-1:0] op,
  input  mcpwm_pkg::count_t             value,
  output mcpwm_pkg::tb_view_t           view
);
  import mcpwm_pkg::*;

  count_t tick_count, tick_count_next;
  count_t active_period, active_period_next;
  count_t pending_period, pending_period_next;
  logic   running, running_next;
  logic   wrapped;
  logic [COUNT_BITS:0] count_inc;

  always_comb begin
    tick_count_next     = tick_count;
    active_period_next  = active_period;
    pending_period_next = pending_period;
    running_next        = running;
    wrapped             = 1'b0;
    count_inc           = {1'b0, tick_count} + (COUNT_BITS+1)'(1);
    case (op)
      OP_TICK: begin
        if (running) begin
          if (count_inc >= {1'b0, active_period}) begin
            tick_count_next    = '0;
            active_period_next = pending_period;
            wrapped            = 1'b1;
          end else begin
            tick_count_next = count_inc[COUNT_BITS-1:0];
          end
        end
      end
      OP_PERIOD:  pending_period_next = value;
      OP_ENABLE:  running_next = 1'b1;
      OP_DISABLE: running_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      active_period  <= RESET_PERIOD;
      pending_period <= RESET_PERIOD;
      running        <= 1'b1;
    end else if (accept) begin
      tick_count     <= tick_count_next;
      active_period  <= active_period_next;
      pending_period <= pending_period_next;
      running        <= running_next;
    end
  end

  assign view.running = running_next;
  assign view.wrapped = wrapped;
  assign view.count   = tick_count_next;

endmodule

/* design/mcpwm_channels.sv */
`timescale 1ns / 1ps

module mcpwm_channels (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [mcpwm_pkg::OP_BITS-1:0]     op,
  input  logic [mcpwm_pkg::CHAN_BITS-1:0]   channel,
  input  mcpwm_pkg::count_t                 value,
  input  logic [mcpwm_pkg::CCOUNT_BITS-1:0] channel_count,
  input  mcpwm_pkg::tb_view_t               view,
  output logic [mcpwm_pkg::PWM_CHANNELS-1:0] levels
);
  import mcpwm_pkg::*;

  count_t active_duty  [PWM_CHANNELS];
  count_t pending_duty [PWM_CHANNELS];
  count_t active_duty_next  [PWM_CHANNELS];
  count_t pending_duty_next [PWM_CHANNELS];

  always_comb begin
    for (int i = 0; i < PWM_CHANNELS; i++) begin
      pending_duty_next[i] = pending_duty[i];
      if (op == OP_DUTY && channel == CHAN_BITS'(i)) begin
        pending_duty_next[i] = value;
      end
      // shadows load on the wrap, using the shadow held before this beat
      active_duty_next[i] = view.wrapped ? pending_duty[i] : active_duty[i];
    end
  end

  always_comb begin
    for (int i = 0; i < PWM_CHANNELS; i++) begin
      levels[i] = view.running
               && (CCOUNT_BITS'(i) < channel_count)
               && (view.count < active_duty_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        active_duty[i]  <= '0;
        pending_duty[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        active_duty[i]  <= active_duty_next[i];
        pending_duty[i] <= pending_duty_next[i];
      end
    end
  end

endmodule
